@@ design/merf_pkg.sv @@
// merf_pkg: shared types, codes and helpers of the MIDI event remap filter.
// No dependencies; imported by every module of the block but merf_fifo.
`default_nettype none

package merf_pkg;

  localparam int TYPE_SLOTS = 8;
  localparam int CHANNELS   = 16;
  localparam int NUMBERS    = 128;
  localparam int SLOT_W     = $clog2(TYPE_SLOTS);
  localparam int CHAN_W     = $clog2(CHANNELS);
  localparam int NUM_W      = $clog2(NUMBERS);
  localparam int KEY_W      = SLOT_W + CHAN_W + NUM_W;

  localparam logic [13:0] PB_CENTER = 14'd8192;
  localparam logic [13:0] PB_MAX    = 14'd16383;

  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;
  localparam logic [3:0] TYPE_BEND     = 4'hE;
  localparam logic [3:0] TYPE_SYSTEM   = 4'hF;
  localparam logic [7:0] STATUS_SYSEX  = 8'hF0;

  // Configuration register index (byte address bit 2).
  localparam logic REG_TUNE_EN     = 1'b0;
  localparam logic REG_TUNE_CENTER = 1'b1;

  typedef enum logic [1:0] {
    OP_MSG   = 2'd0,
    OP_MAP   = 2'd1,
    OP_XPOSE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_THRU   = 2'd0,
    KIND_IGNORE = 2'd1,
    KIND_SWAP   = 2'd2,
    KIND_RETYPE = 2'd3
  } kind_e;

  typedef struct packed {
    logic [3:0] typ;
    logic [3:0] chan;
    logic [6:0] num;
  } tgt_t;

  // Remapped message handed from the front to the back. Data bytes are
  // carried unmasked; the back masks them by length.
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [1:0] len;
  } job_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [1:0] len;
    logic       last;
  } res_t;

  // Saturating bend retune: center + pb - 8192, clipped to 0..16383.
  function automatic logic [13:0] tuned_bend(input logic [13:0] center,
                                             input logic [13:0] pb);
    logic signed [15:0] t;
    t = $signed({2'b00, center}) + $signed({2'b00, pb}) - $signed({2'b00, PB_CENTER});
    if (t < 16'sd0) begin
      tuned_bend = 14'd0;
    end else if (t > $signed({2'b00, PB_MAX})) begin
      tuned_bend = PB_MAX;
    end else begin
      tuned_bend = t[13:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ design/midi_event_remap_filter.sv @@
// midi_event_remap_filter: top level; configuration registers and the
// front / job queue / back / result queue chain. Depends on merf_pkg.
`default_nettype none

// Channel   Handshake             Payload
// --------  --------------------  -----------------------------------------
// items     push / full           op, status, data1, data2, msg_len, entry_*
// results   empty / pop           out_status, out_data1, out_data2, out_len,
//                                 last
// config    APB (psel..pready)    0x0 tune_enable, 0x4 tune_center
//
// The front takes one item per cycle while full is low. The back emits one
// result per cycle while the result queue has room, so a note-on with tuning
// on yields two results (tuned bend, then the note); everything else yields one.
// An accepted item is registered in the lookup stage, then in the job queue,
// then in the result queue, whose head drives the result ports.
// After reset, full stays high while all 16384 remap memory entries are
// swept to identity entries, one per cycle; config writes work meanwhile.
// The job queue lets the front keep accepting while the back stalls; full
// rises when the lookup stage holds an item and the job queue is full.

module midi_event_remap_filter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // item queue
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        op_i,
  input  wire logic [7:0]        status_i,
  input  wire logic [7:0]        data1_i,
  input  wire logic [7:0]        data2_i,
  input  wire logic [1:0]        msg_len_i,
  input  wire logic [1:0]        entry_kind_i,
  input  wire logic [3:0]        entry_type_i,
  input  wire logic [3:0]        entry_chan_i,
  input  wire logic [6:0]        entry_num_i,
  input  wire logic signed [6:0] shift_amount_i,
  // result queue
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             out_status_o,
  output logic [6:0]             out_data1_o,
  output logic [6:0]             out_data2_o,
  output logic [1:0]             out_len_o,
  output logic                   last_o,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import merf_pkg::*;

  logic        tune_en_q;
  logic [13:0] tune_center_q;

  logic        job_push, job_full, job_empty, job_pop;
  job_t        job_in, job_head;
  logic        res_push, res_full;
  res_t        res_in, res_head;

  // --- configuration registers ---
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tune_en_q     <= 1'b0;
      tune_center_q <= PB_CENTER;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TUNE_EN:     tune_en_q     <= pwdata[0];
        REG_TUNE_CENTER: tune_center_q <= pwdata[13:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TUNE_EN:     prdata = {31'd0, tune_en_q};
      REG_TUNE_CENTER: prdata = {18'd0, tune_center_q};
      default:         prdata = '0;
    endcase
  end

  // --- front: accept, table writes, lookup, transpose ---
  merf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .op_i           (op_e'(op_i)),
    .status_i       (status_i),
    .data1_i        (data1_i),
    .data2_i        (data2_i),
    .msg_len_i      (msg_len_i),
    .entry_kind_i   (kind_e'(entry_kind_i)),
    .entry_type_i   (entry_type_i),
    .entry_chan_i   (entry_chan_i),
    .entry_num_i    (entry_num_i),
    .shift_amount_i (shift_amount_i),
    .job_push_o     (job_push),
    .job_o          (job_in),
    .job_full_i     (job_full)
  );

  // --- job queue between front and back ---
  merf_fifo #(
    .Width ($bits(job_t))
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .rdata_o (job_head)
  );

  // --- back: tuning and result generation ---
  merf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tune_en_i     (tune_en_q),
    .tune_center_i (tune_center_q),
    .job_empty_i   (job_empty),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .res_push_o    (res_push),
    .res_o         (res_in),
    .res_full_i    (res_full)
  );

  // --- result queue; its head drives the result ports ---
  merf_fifo #(
    .Width ($bits(res_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_head)
  );

  assign out_status_o = res_head.status;
  assign out_data1_o  = res_head.d1;
  assign out_data2_o  = res_head.d2;
  assign out_len_o    = res_head.len;
  assign last_o       = res_head.last;

endmodule

`default_nettype wire

@@ design/merf_fifo.sv @@
// merf_fifo: two-entry queue of packed words, used between front and back
// and as the result queue. Depends on nothing.
`default_nettype none

module merf_fifo #(
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [Width-1:0] rdata_o
);

  localparam int Depth = 2;

  logic [Width-1:0]         mem_q [Depth];
  logic                     wr_ptr_q, wr_ptr_d;
  logic                     rd_ptr_q, rd_ptr_d;
  logic [$clog2(Depth):0]   cnt_q, cnt_d;
  logic                     do_push, do_pop;

  assign full_o  = (cnt_q == ($clog2(Depth)+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {{$clog2(Depth){1'b0}}, do_push} - {{$clog2(Depth){1'b0}}, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ design/merf_front.sv @@
// merf_front: accepts items, applies table writes, looks up the remap
// table and transposes notes. Depends on merf_pkg.
`default_nettype none

module merf_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item side
  input  wire logic               push,
  output logic                    full,
  input  wire merf_pkg::op_e      op_i,
  input  wire logic [7:0]         status_i,
  input  wire logic [7:0]         data1_i,
  input  wire logic [7:0]         data2_i,
  input  wire logic [1:0]         msg_len_i,
  input  wire merf_pkg::kind_e    entry_kind_i,
  input  wire logic [3:0]         entry_type_i,
  input  wire logic [3:0]         entry_chan_i,
  input  wire logic [6:0]         entry_num_i,
  input  wire logic signed [6:0]  shift_amount_i,
  // job queue side
  output logic                    job_push_o,
  output merf_pkg::job_t          job_o,
  input  wire logic               job_full_i
);

  import merf_pkg::*;

  // remap table, split so an ignore write leaves the target alone
  logic [1:0]       kind_mem [2**KEY_W];
  tgt_t             tgt_mem  [2**KEY_W];

  logic             clr_q;
  logic [KEY_W-1:0] clr_cnt_q;

  logic signed [6:0] xpose_q [CHANNELS];

  // lookup stage
  logic             s1_valid_q;
  logic [7:0]       s1_status_q;
  logic [6:0]       s1_d1_q, s1_d2_q, s1_val_q;
  logic [1:0]       s1_len_q;
  logic [1:0]       kind_rd_q;
  tgt_t             tgt_rd_q;

  logic             accept, take, advance;
  logic [3:0]       in_type, in_chan;
  logic [1:0]       in_len;
  logic [6:0]       in_num, in_val;
  logic [KEY_W-1:0] rd_key, wr_key;
  logic             map_wr, xpose_wr;
  logic             kind_we, tgt_we;
  logic [1:0]       kind_wdata;
  tgt_t             tgt_wdata;

  logic             drop;
  logic [3:0]       ntype, nchan;
  logic [6:0]       nd1, nd2;
  logic [1:0]       nlen;
  logic [8:0]       note_sum;
  logic signed [6:0] xpose;

  assign full    = clr_q | (s1_valid_q & job_full_i);
  assign accept  = push & ~full;
  assign in_type = status_i[7:4];
  assign in_chan = status_i[3:0];
  assign in_len  = (msg_len_i == 2'd0) ? 2'd1 : msg_len_i;
  assign in_num  = (in_len == 2'd3 && in_type != TYPE_BEND) ? data1_i[6:0] : 7'd0;
  assign in_val  = (in_len == 2'd3) ? data2_i[6:0] : data1_i[6:0];
  assign rd_key  = {in_type[SLOT_W-1:0], in_chan, in_num};
  assign wr_key  = {in_type[SLOT_W-1:0], in_chan, data1_i[6:0]};
  assign take    = accept & (op_i == OP_MSG) & (status_i != STATUS_SYSEX);

  always_comb begin
    map_wr   = 1'b0;
    xpose_wr = 1'b0;
    unique case (op_i)
      OP_MAP: begin
        map_wr = accept & (in_type != TYPE_SYSTEM) & ~data1_i[7] &
                 ~(entry_kind_i == KIND_RETYPE && entry_type_i == TYPE_SYSTEM);
      end
      OP_XPOSE: begin
        xpose_wr = accept & (shift_amount_i >= -7'sd60) & (shift_amount_i <= 7'sd60);
      end
      OP_MSG, OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // write port: clearing pass after reset, then map writes
  always_comb begin
    if (clr_q) begin
      kind_we    = 1'b1;
      tgt_we     = 1'b1;
      kind_wdata = KIND_THRU;
      tgt_wdata  = '{typ:  {1'b1, clr_cnt_q[KEY_W-1 -: SLOT_W]},
                     chan: clr_cnt_q[NUM_W +: CHAN_W],
                     num:  clr_cnt_q[NUM_W-1:0]};
    end else begin
      kind_we    = map_wr;
      tgt_we     = map_wr & (entry_kind_i != KIND_IGNORE);
      kind_wdata = entry_kind_i;
      tgt_wdata  = '{typ: entry_type_i, chan: entry_chan_i, num: entry_num_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (kind_we) begin
      kind_mem[clr_q ? clr_cnt_q : wr_key] <= kind_wdata;
    end
    if (tgt_we) begin
      tgt_mem[clr_q ? clr_cnt_q : wr_key] <= tgt_wdata;
    end
    if (accept) begin
      kind_rd_q <= kind_mem[rd_key];
      tgt_rd_q  <= tgt_mem[rd_key];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        xpose_q[i] <= '0;
      end
    end else if (xpose_wr) begin
      xpose_q[in_chan] <= shift_amount_i;
    end
  end

  // remap and transpose of the item in the lookup stage
  always_comb begin
    drop  = 1'b0;
    ntype = s1_status_q[7:4];
    nchan = s1_status_q[3:0];
    nd1   = s1_d1_q;
    nd2   = s1_d2_q;
    nlen  = s1_len_q;
    unique case (kind_e'(kind_rd_q))
      KIND_THRU: begin
      end
      KIND_IGNORE: begin
        drop = 1'b1;
      end
      KIND_SWAP: begin
        nchan = tgt_rd_q.chan;
        nd1   = tgt_rd_q.num;
        nd2   = s1_val_q;
        nlen  = 2'd3;
      end
      KIND_RETYPE: begin
        ntype = tgt_rd_q.typ;
        nchan = tgt_rd_q.chan;
        if (ntype == TYPE_PROGRAM || ntype == TYPE_PRESSURE) begin
          nd1  = s1_val_q;
          nd2  = 7'd0;
          nlen = 2'd2;
        end else if (ntype == TYPE_BEND) begin
          nd1  = 7'd0;
          nd2  = s1_val_q;
          nlen = 2'd3;
        end else begin
          nd1  = tgt_rd_q.num;
          nd2  = s1_val_q;
          nlen = 2'd3;
        end
      end
      default: begin
      end
    endcase
    xpose    = xpose_q[nchan];
    note_sum = {2'b00, nd1} + {{2{xpose[6]}}, xpose};
    if (ntype == TYPE_NOTE_OFF || ntype == TYPE_NOTE_ON) begin
      nd1 = note_sum[6:0];
      if (note_sum[8:7] != 2'b00) begin
        drop = 1'b1;
      end
    end
  end

  assign advance    = s1_valid_q & (drop | ~job_full_i);
  assign job_push_o = s1_valid_q & ~drop;
  assign job_o      = '{status: {ntype, nchan}, d1: nd1, d2: nd2, len: nlen};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= take;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_status_q <= status_i;
      s1_d1_q     <= data1_i[6:0];
      s1_d2_q     <= data2_i[6:0];
      s1_val_q    <= in_val;
      s1_len_q    <= in_len;
    end
  end

endmodule

`default_nettype wire

@@ design/merf_back.sv @@
// merf_back: bend tuning, per-channel last bend and the tuned bend that
// precedes a note-on. Depends on merf_pkg.
`default_nettype none

module merf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            tune_en_i,
  input  wire logic [13:0]     tune_center_i,
  // job queue head
  input  wire logic            job_empty_i,
  input  wire merf_pkg::job_t  job_i,
  output logic                 job_pop_o,
  // result queue
  output logic                 res_push_o,
  output merf_pkg::res_t       res_o,
  input  wire logic            res_full_i
);

  import merf_pkg::*;

  logic [13:0] last_bend_q [CHANNELS];
  logic        bend_sent_q;

  logic [3:0]  chan;
  logic        is_note_on, is_bend, need_bend, fire;
  logic [13:0] pb_in, tuned_in, tuned_last;
  logic [6:0]  d1v, d2v;

  assign chan       = job_i.status[3:0];
  assign is_note_on = (job_i.status[7:4] == TYPE_NOTE_ON);
  assign is_bend    = (job_i.status[7:4] == TYPE_BEND);
  assign need_bend  = tune_en_i & is_note_on & ~bend_sent_q;
  assign fire       = ~job_empty_i & ~res_full_i;
  assign pb_in      = {job_i.d2, job_i.d1};
  assign tuned_in   = tuned_bend(tune_center_i, pb_in);
  assign tuned_last = tuned_bend(tune_center_i, last_bend_q[chan]);

  assign res_push_o = fire;
  assign job_pop_o  = fire & ~need_bend;

  always_comb begin
    if (tune_en_i && is_bend) begin
      d1v = tuned_in[6:0];
      d2v = tuned_in[13:7];
    end else begin
      d1v = job_i.d1;
      d2v = job_i.d2;
    end
    if (need_bend) begin
      res_o = '{status: {TYPE_BEND, chan}, d1: tuned_last[6:0], d2: tuned_last[13:7],
                len: 2'd3, last: 1'b0};
    end else begin
      res_o = '{status: job_i.status,
                d1:     (job_i.len >= 2'd2) ? d1v : 7'd0,
                d2:     (job_i.len == 2'd3) ? d2v : 7'd0,
                len:    job_i.len,
                last:   1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bend_sent_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_bend_q[i] <= PB_CENTER;
      end
    end else if (fire) begin
      bend_sent_q <= need_bend;
      if (!need_bend && tune_en_i && is_bend) begin
        last_bend_q[chan] <= pb_in;
      end
    end
  end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// testbench: self-checking bench for midi_event_remap_filter; keeps its own
// copy of the remap, transpose and bend tables and checks every result.
// Depends on merf_pkg and the design sources; no files, no arguments.

module testbench;
  import merf_pkg::*;

  // One input transaction as the item port sees it.
  typedef struct {
    op_e              op;
    logic [7:0]       status;
    logic [7:0]       data1;
    logic [7:0]       data2;
    logic [1:0]       msg_len;
    kind_e            kind;
    logic [3:0]       etype;
    logic [3:0]       echan;
    logic [6:0]       ent_num;
    logic signed [6:0] shift;
  } midi_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] typ;
    logic [3:0] chan;
    logic [6:0] num;
  } map_entry_t;

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              push      = 1'b0;
  logic [1:0]        op_i      = '0;
  logic [7:0]        status_i  = '0;
  logic [7:0]        data1_i   = '0;
  logic [7:0]        data2_i   = '0;
  logic [1:0]        msg_len_i = '0;
  logic [1:0]        entry_kind_i = '0;
  logic [3:0]        entry_type_i = '0;
  logic [3:0]        entry_chan_i = '0;
  logic [6:0]        entry_num_i  = '0;
  logic signed [6:0] shift_amount_i = '0;
  logic              pop     = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [2:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic              full;
  logic              empty;
  logic [7:0]        out_status_o;
  logic [6:0]        out_data1_o;
  logic [6:0]        out_data2_o;
  logic [1:0]        out_len_o;
  logic              last_o;
  logic [31:0]       prdata;
  logic              pready;

  midi_event_remap_filter dut (
    .clk_i, .rst_ni,
    .push, .full,
    .op_i, .status_i, .data1_i, .data2_i, .msg_len_i,
    .entry_kind_i, .entry_type_i, .entry_chan_i, .entry_num_i, .shift_amount_i,
    .empty, .pop,
    .out_status_o, .out_data1_o, .out_data2_o, .out_len_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Shadow state of the filter.
  map_entry_t        remap_mem [TYPE_SLOTS*CHANNELS*NUMBERS];
  logic signed [6:0] xpose_mem [CHANNELS];
  logic [13:0]       bend_mem  [CHANNELS];
  logic              tune_en_q;
  logic [13:0]       tune_center_q;
  res_t              pending_res [$];

  int errors         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run (memory sweep included).
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void init_tables();
    for (int s = 0; s < TYPE_SLOTS; s++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int n = 0; n < NUMBERS; n++) begin
          remap_mem[(s*CHANNELS + c)*NUMBERS + n] = '{KIND_THRU, 4'(s + 8), 4'(c), 7'(n)};
        end
      end
    end
    for (int c = 0; c < CHANNELS; c++) begin
      xpose_mem[c] = '0;
      bend_mem[c]  = PB_CENTER;
    end
    tune_en_q     = 1'b0;
    tune_center_q = PB_CENTER;
  endfunction

  // center + pb - 8192, clipped to the 14 bit bend range
  function automatic logic [13:0] retune(input logic [13:0] pb);
    int t;
    t = int'(tune_center_q) + int'(pb) - 8192;
    if (t < 0) begin
      t = 0;
    end else if (t > 16383) begin
      t = 16383;
    end
    return t[13:0];
  endfunction

  // Applies one accepted transaction to the shadow tables and queues the
  // results it should produce.
  function automatic void remap_predict(input midi_item_t it);
    logic [3:0]  typ;
    logic [3:0]  chan;
    logic [7:0]  st;
    logic [6:0]  d1, d2, num, val;
    logic [1:0]  len;
    logic [13:0] key, pb;
    map_entry_t  ent;
    int          note, sh;
    res_t        r;
    typ  = it.status[7:4];
    chan = it.status[3:0];
    case (it.op)
      OP_MAP: begin
        if (typ == TYPE_SYSTEM || it.data1[7]) return;
        if (it.kind == KIND_RETYPE && it.etype == TYPE_SYSTEM) return;
        key = {typ[2:0], chan, it.data1[6:0]};
        remap_mem[key].kind = it.kind;
        // ignore keeps the stored target
        if (it.kind != KIND_IGNORE) begin
          remap_mem[key].typ  = it.etype;
          remap_mem[key].chan = it.echan;
          remap_mem[key].num  = it.ent_num;
        end
        return;
      end
      OP_XPOSE: begin
        sh = it.shift;
        if (sh >= -60 && sh <= 60) xpose_mem[chan] = it.shift;
        return;
      end
      OP_NONE: return;
      default: ;
    endcase

    if (it.status == STATUS_SYSEX) return;
    st  = it.status;
    d1  = it.data1[6:0];
    d2  = it.data2[6:0];
    len = (it.msg_len == 2'd0) ? 2'd1 : it.msg_len;
    // short messages and bends look up number 0
    if (len == 2'd3) begin
      num = (typ == TYPE_BEND) ? 7'd0 : d1;
      val = d2;
    end else begin
      num = 7'd0;
      val = d1;
    end

    ent = remap_mem[{typ[2:0], chan, num}];
    if (ent.kind == KIND_IGNORE) return;
    if (ent.kind == KIND_SWAP || ent.kind == KIND_RETYPE) begin
      if (ent.kind == KIND_RETYPE) typ = ent.typ;
      chan = ent.chan;
      st   = {typ, chan};
      if (ent.kind == KIND_RETYPE && (typ == TYPE_PROGRAM || typ == TYPE_PRESSURE)) begin
        d1  = val;
        d2  = 7'd0;
        len = 2'd2;
      end else if (ent.kind == KIND_RETYPE && typ == TYPE_BEND) begin
        d1  = 7'd0;
        d2  = val;
        len = 2'd3;
      end else begin
        d1  = ent.num;
        d2  = val;
        len = 2'd3;
      end
    end

    if ((typ == TYPE_NOTE_OFF || typ == TYPE_NOTE_ON) && xpose_mem[chan] != 0) begin
      note = int'(d1) + int'(xpose_mem[chan]);
      if (note < 0 || note > 127) return;
      d1 = note[6:0];
    end

    if (tune_en_q) begin
      if (typ == TYPE_NOTE_ON) begin
        // tuned bend ahead of the note
        pb       = retune(bend_mem[chan]);
        r.status = {TYPE_BEND, chan};
        r.d1     = pb[6:0];
        r.d2     = pb[13:7];
        r.len    = 2'd3;
        r.last   = 1'b0;
        pending_res.push_back(r);
      end else if (typ == TYPE_BEND) begin
        pb             = {d2, d1};
        bend_mem[chan] = pb;
        pb             = retune(pb);
        d1             = pb[6:0];
        d2             = pb[13:7];
      end
    end

    r.status = st;
    r.d1     = (len >= 2'd2) ? d1 : 7'd0;
    r.d2     = (len == 2'd3) ? d2 : 7'd0;
    r.len    = len;
    r.last   = 1'b1;
    pending_res.push_back(r);
  endfunction

  function automatic void check_field(input string fname, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
      end
    end
  endfunction

  // Result side: random pop stalls, every popped transaction checked
  // against the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    res_t want;
    if (rst_ni && !empty && pop) begin
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: result status %0h arrived with none expected", $time, out_status_o);
        end
      end else begin
        want = pending_res.pop_front();
        check_field("out_status", want.status, out_status_o);
        check_field("out_data1", want.d1, out_data1_o);
        check_field("out_data2", want.d2, out_data2_o);
        check_field("out_len", want.len, out_len_o);
        check_field("last", want.last, last_o);
      end
    end
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one transaction; push stays high afterwards so back-to-back
  // items follow without an idle gap.
  task automatic send_item(input midi_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    op_i           <= it.op;
    status_i       <= it.status;
    data1_i        <= it.data1;
    data2_i        <= it.data2;
    msg_len_i      <= it.msg_len;
    entry_kind_i   <= it.kind;
    entry_type_i   <= it.etype;
    entry_chan_i   <= it.echan;
    entry_num_i    <= it.ent_num;
    shift_amount_i <= it.shift;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    remap_predict(it);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_TUNE_EN) begin
      tune_en_q = value[0];
    end else begin
      tune_center_q = value[13:0];
    end
    @(posedge clk_i);
  endtask

  // Wait for every predicted result, up to a guard limit, then let dropped
  // items still in the pipe drain out.
  task automatic drain_results();
    int guard;
    push <= 1'b0;
    guard = 0;
    while (pending_res.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  function automatic midi_item_t make_item(input op_e op, input logic [7:0] st,
                                           input logic [7:0] d1, input logic [7:0] d2,
                                           input logic [1:0] len);
    midi_item_t it;
    it.op      = op;
    it.status  = st;
    it.data1   = d1;
    it.data2   = d2;
    it.msg_len = len;
    it.kind    = KIND_THRU;
    it.etype   = 4'h0;
    it.echan   = 4'h0;
    it.ent_num = 7'd0;
    it.shift   = 7'sd0;
    return it;
  endfunction

  function automatic midi_item_t make_map(input logic [7:0] st, input logic [7:0] key,
                                          input kind_e kind, input logic [3:0] etype,
                                          input logic [3:0] echan, input logic [6:0] num);
    midi_item_t it;
    it         = make_item(OP_MAP, st, key, 8'h00, 2'd3);
    it.kind    = kind;
    it.etype   = etype;
    it.echan   = echan;
    it.ent_num = num;
    return it;
  endfunction

  function automatic midi_item_t make_xpose(input logic [3:0] chan, input int amount);
    midi_item_t it;
    it       = make_item(OP_XPOSE, {4'h0, chan}, 8'h00, 8'h00, 2'd3);
    it.shift = 7'(amount);
    return it;
  endfunction

  // Numbers cluster on 0 and a few low keys so that lookups hit written
  // entries; the top of the note range exercises the transpose drop.
  function automatic logic [7:0] pick_number();
    int p;
    p = $urandom_range(99);
    if (p < 40) return 8'd0;
    if (p < 70) return 8'($urandom_range(7));
    if (p < 85) return 8'($urandom_range(127, 120));
    return 8'($urandom_range(255));
  endfunction

  function automatic midi_item_t random_item();
    midi_item_t it;
    int         p;
    logic [3:0] chan;
    p    = $urandom_range(99);
    chan = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    it   = make_item(OP_MSG, {4'($urandom_range(14, 8)), chan}, pick_number(),
                     8'($urandom_range(255)), 2'd3);
    it.kind    = kind_e'($urandom_range(3));
    it.etype   = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(14, 8));
    it.echan   = ($urandom_range(1) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    it.ent_num = 7'($urandom_range(127));
    it.shift   = 7'($urandom_range(120) - 60);
    if (p < 8) begin
      // noise: every field at random, bad writes and op 3 included
      it.op      = op_e'($urandom_range(3));
      it.status  = 8'($urandom_range(255));
      it.data1   = 8'($urandom_range(255));
      it.msg_len = 2'($urandom_range(3));
      it.etype   = 4'($urandom_range(15));
      it.shift   = 7'($urandom_range(127));
    end else if (p < 22) begin
      it.op = OP_MAP;
    end else if (p < 28) begin
      it.op = OP_XPOSE;
      if ($urandom_range(7) == 0) it.shift = 7'($urandom_range(127));
    end else begin
      if (it.status[7:4] == TYPE_PROGRAM || it.status[7:4] == TYPE_PRESSURE) begin
        it.msg_len = 2'd2;
      end
      if ($urandom_range(9) == 0) it.msg_len = 2'($urandom_range(3));
      if ($urandom_range(19) == 0) it.status = STATUS_SYSEX;
      if ($urandom_range(19) == 0) it.status = 8'($urandom_range(255));
    end
    return it;
  endfunction

  // Plain messages through the identity table, default config.
  task automatic test_directed_messages();
    send_item(make_item(OP_MSG, STATUS_SYSEX, 8'h10, 8'h20, 2'd3));
    send_item(make_item(OP_MSG, 8'h90, 8'h3C, 8'h64, 2'd3));
    send_item(make_item(OP_MSG, 8'h81, 8'hFF, 8'hFF, 2'd3));
    send_item(make_item(OP_MSG, 8'hC3, 8'h05, 8'h77, 2'd2));
    send_item(make_item(OP_MSG, 8'hD4, 8'h7F, 8'h00, 2'd2));
    send_item(make_item(OP_MSG, 8'hF8, 8'h12, 8'h34, 2'd1));
    send_item(make_item(OP_MSG, 8'hA2, 8'h55, 8'h66, 2'd0));
    send_item(make_item(OP_MSG, 8'hEF, 8'h00, 8'h40, 2'd3));
    send_item(make_item(OP_MSG, 8'h35, 8'h11, 8'h22, 2'd3));
    send_item(make_item(OP_NONE, 8'h90, 8'h40, 8'h40, 2'd3));
    drain_results();
  endtask

  // Remap entries of the ignore, swap and retype kinds, rejected writes, transpose limits.
  task automatic test_directed_tables();
    send_item(make_map(8'hB0, 8'd7, KIND_RETYPE, TYPE_PROGRAM, 4'd9, 7'd0));
    send_item(make_item(OP_MSG, 8'hB0, 8'h07, 8'h55, 2'd3));
    send_item(make_map(8'h90, 8'd61, KIND_IGNORE, 4'h8, 4'd3, 7'd3));
    send_item(make_item(OP_MSG, 8'h90, 8'd61, 8'h40, 2'd3));
    send_item(make_map(8'h91, 8'd10, KIND_SWAP, 4'h8, 4'd5, 7'd20));
    send_item(make_item(OP_MSG, 8'h91, 8'd10, 8'h30, 2'd3));
    send_item(make_map(8'hA0, 8'd0, KIND_RETYPE, TYPE_BEND, 4'd2, 7'd9));
    send_item(make_item(OP_MSG, 8'hA0, 8'h33, 8'h00, 2'd2));
    // rejected: system key type, key above 127, retype to system
    send_item(make_map(8'hF1, 8'd1, KIND_IGNORE, 4'h8, 4'd0, 7'd0));
    send_item(make_map(8'hB1, 8'h80, KIND_IGNORE, 4'h8, 4'd0, 7'd0));
    send_item(make_map(8'hB1, 8'd0, KIND_RETYPE, TYPE_SYSTEM, 4'd0, 7'd0));
    send_item(make_item(OP_MSG, 8'hB1, 8'h00, 8'h01, 2'd3));
    send_item(make_xpose(4'd2, 60));
    send_item(make_item(OP_MSG, 8'h92, 8'd67, 8'h40, 2'd3));
    send_item(make_item(OP_MSG, 8'h92, 8'd68, 8'h40, 2'd3));
    send_item(make_xpose(4'd3, -60));
    send_item(make_item(OP_MSG, 8'h83, 8'd59, 8'h40, 2'd3));
    send_item(make_item(OP_MSG, 8'h83, 8'd60, 8'h40, 2'd3));
    send_item(make_xpose(4'd3, 61));
    send_item(make_xpose(4'd3, -61));
    send_item(make_item(OP_MSG, 8'h83, 8'd127, 8'h40, 2'd3));
    drain_results();
  endtask

  // Saturating retune at both ends of the center range.
  task automatic test_directed_tuning();
    write_reg(REG_TUNE_EN, 32'd1);
    write_reg(REG_TUNE_CENTER, 32'(PB_MAX));
    send_item(make_item(OP_MSG, 8'hE0, 8'h7F, 8'h7F, 2'd3));
    send_item(make_item(OP_MSG, 8'h90, 8'h40, 8'h40, 2'd3));
    drain_results();
    write_reg(REG_TUNE_CENTER, 32'd0);
    send_item(make_item(OP_MSG, 8'hE1, 8'h00, 8'h00, 2'd3));
    send_item(make_item(OP_MSG, 8'h91, 8'h40, 8'h40, 2'd3));
    send_item(make_item(OP_MSG, 8'h94, 8'h40, 8'h40, 2'd3));
    drain_results();
  endtask

  task automatic test_random_traffic(input logic tune_en, input logic [13:0] center,
                                     input int send_pct, input int recv_pct, input int count);
    write_reg(REG_TUNE_EN, {31'd0, tune_en});
    write_reg(REG_TUNE_CENTER, {18'd0, center});
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_item(random_item());
    drain_results();
  endtask

  initial begin
    init_tables();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_messages();
    test_directed_tables();
    test_directed_tuning();
    test_random_traffic(1'b0, PB_CENTER, 0, 0, 300);
    test_random_traffic(1'b1, 14'd0, 66, 0, 300);
    test_random_traffic(1'b1, PB_MAX, 0, 66, 300);
    test_random_traffic(1'b1, 14'($urandom_range(16383)), 37, 37, 350);
    test_random_traffic(1'b0, PB_MAX, 37, 37, 300);
    test_random_traffic(1'b1, PB_CENTER, 0, 0, 300);

    if (pending_res.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_res.size());
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
